FILE: src/postfix_stack_evaluator_assert.svh
// Assertion macros for the postfix stack evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PSE_ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("postfix evaluator: invariant violated");
`define PSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("postfix evaluator: sequence violated");
`else
`define PSE_ASSERT_HOLDS(lbl, clk, rst, prop)
`define PSE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/pse_pkg.sv
package pse_pkg;

   localparam int PSE_STACK_DEPTH = 32;
   localparam int DATA_W = 32;

   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_POW  = 3'd5;

   // Value produced by a pop from an empty stack.
   localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [2:0]               operation;
      logic signed [DATA_W-1:0] operand_value;
      logic                     last_token;
   } pse_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic                     divide_by_zero;
      logic                     stack_overflow;
      logic                     stack_underflow;
   } pse_rsp_type;

   typedef struct packed {
      logic start;
      logic is_pow;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } alu_sts_type;

endpackage

FILE: src/pse_stack_mem.sv
module pse_stack_mem import pse_pkg::*; #(
   parameter int DEPTH = PSE_STACK_DEPTH,
   parameter int AW    = $clog2(PSE_STACK_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pse_alu.sv
module pse_alu import pse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  alu_ctl_type       ctl,
   input  logic [DATA_W-1:0] b,
   input  logic [DATA_W-1:0] a,
   output alu_sts_type       sts,
   output logic [DATA_W-1:0] result
);

   typedef enum logic [1:0] {A_IDLE, A_DIV, A_POW} alu_state_type;

   alu_state_type     state_ff;
   logic [4:0]        cnt_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] dvs_ff;
   logic              neg_ff;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] sq_ff;
   logic [DATA_W-1:0] ex_ff;
   logic [DATA_W-1:0] result_ff;
   logic              done_ff;
   logic              dz_ff;

   logic [DATA_W:0]   trial;
   logic [DATA_W-1:0] prod_acc;
   logic [DATA_W-1:0] prod_sq;
   logic [DATA_W-1:0] b_mag;
   logic [DATA_W-1:0] a_mag;

   assign trial    = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};
   assign prod_acc = DATA_W'(acc_ff * sq_ff);
   assign prod_sq  = DATA_W'(sq_ff * sq_ff);
   assign b_mag    = b[DATA_W-1] ? DATA_W'(-b) : b;
   assign a_mag    = a[DATA_W-1] ? DATA_W'(-a) : a;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
         dz_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         dz_ff   <= 1'b0;
         case (state_ff)
            A_IDLE: begin
               if (ctl.start && !ctl.is_pow) begin
                  if (a == '0) begin
                     result_ff <= '0;
                     dz_ff     <= 1'b1;
                     done_ff   <= 1'b1;
                  end else begin
                     rem_ff   <= '0;
                     quo_ff   <= b_mag;
                     dvs_ff   <= a_mag;
                     neg_ff   <= b[DATA_W-1] ^ a[DATA_W-1];
                     cnt_ff   <= '0;
                     state_ff <= A_DIV;
                  end
               end else if (ctl.start) begin
                  if (a[DATA_W-1]) begin
                     // A negative exponent only survives for bases of magnitude one.
                     done_ff <= 1'b1;
                     if (b == DATA_W'(1)) begin
                        result_ff <= DATA_W'(1);
                     end else if (b == '1) begin
                        result_ff <= a[0] ? '1 : DATA_W'(1);
                     end else begin
                        result_ff <= '0;
                        dz_ff     <= (b == '0);
                     end
                  end else begin
                     acc_ff   <= DATA_W'(1);
                     sq_ff    <= b;
                     ex_ff    <= a;
                     state_ff <= A_POW;
                  end
               end
            end
            A_DIV: begin
               if (!trial[DATA_W]) begin
                  rem_ff <= trial[DATA_W-1:0];
               end else begin
                  rem_ff <= {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
               end
               quo_ff <= {quo_ff[DATA_W-2:0], ~trial[DATA_W]};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= A_IDLE;
                  done_ff  <= 1'b1;
                  if (neg_ff) begin
                     result_ff <= DATA_W'(-{quo_ff[DATA_W-2:0], ~trial[DATA_W]});
                  end else begin
                     result_ff <= {quo_ff[DATA_W-2:0], ~trial[DATA_W]};
                  end
               end
            end
            A_POW: begin
               if (ex_ff == '0) begin
                  result_ff <= acc_ff;
                  done_ff   <= 1'b1;
                  state_ff  <= A_IDLE;
               end else begin
                  if (ex_ff[0]) begin
                     acc_ff <= prod_acc;
                  end
                  sq_ff <= prod_sq;
                  ex_ff <= {1'b0, ex_ff[DATA_W-1:1]};
               end
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign sts.done     = done_ff;
   assign sts.div_zero = dz_ff;
   assign result       = result_ff;

endmodule

FILE: src/postfix_stack_evaluator.sv
// Postfix expression evaluator.
// Requests arrive on req_valid / req_stall / req_payload, one postfix token
// each: an operand push or a binary operator (add, subtract, multiply,
// divide, power) that pops a, then b, and pushes b op a. A token flagged as
// last_token produces one response on rsp_valid / rsp_stall / rsp_payload
// holding the top of stack (zero when empty) and the sticky error flags; the
// stack and the flags are then cleared for the next expression.
// The stack sits in a synchronous memory with a registered read; the top
// entry is mirrored in a register so only the second operand is read.
// Work per request: an operand push is written to memory at accept; add,
// subtract and multiply read the second operand, compute and write back;
// divide runs 32 quotient steps in the shared divide and power unit, and
// power a step per significant exponent bit; that unit sets the worst case.
// A response is loaded into the output register from the done state once
// it is free. While the receiver stalls, the response is held and the
// evaluator keeps accepting tokens until a second response would be needed.
// Synchronous reset empties the stack, clears the flags and drops any
// pending response; memory contents are not cleared and need no sweep.
`include "postfix_stack_evaluator_assert.svh"

module postfix_stack_evaluator import pse_pkg::*; #(
   parameter int STACK_DEPTH = PSE_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pse_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pse_rsp_type rsp_payload
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] TWO_C   = CW'(2);

   typedef enum logic [2:0] {S_IDLE, S_READB, S_ALU, S_WRITE, S_DONE} state_type;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic              last_ff, last_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              dz_ff, dz_in;
   logic              ovf_ff, ovf_in;
   logic              unf_ff, unf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pse_rsp_type       rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              emit;
   logic [CW-1:0]     cnt_m2;
   logic              has_two;
   logic [DATA_W-1:0] b_val;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;

   alu_ctl_type       alu_ctl;
   alu_sts_type       alu_sts;
   logic [DATA_W-1:0] alu_result;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff == S_DONE) && last_ff && out_free;
   assign cnt_m2   = count_ff - TWO_C;
   assign has_two  = (count_ff >= TWO_C);
   assign b_val    = has_two ? rd_data : POP_EMPTY_VALUE;

   // Memory write port: operand pushes at accept, operator results later.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = req_payload.operand_value;
      if (accept && req_payload.operation == OP_PUSH && count_ff < DEPTH_C) begin
         wr_en = 1'b1;
      end else if (state_ff == S_WRITE) begin
         wr_en   = 1'b1;
         wr_addr = has_two ? cnt_m2[AW-1:0] : '0;
         wr_data = res_ff;
      end
   end

   always_comb begin
      alu_ctl.start  = 1'b0;
      alu_ctl.is_pow = (op_ff == OP_POW);
      if (state_ff == S_READB && (op_ff == OP_DIV || op_ff == OP_POW)) begin
         alu_ctl.start = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      a_in         = a_ff;
      res_in       = res_ff;
      dz_in        = dz_ff;
      ovf_in       = ovf_ff;
      unf_in       = unf_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_payload.operation;
               last_in = req_payload.last_token;
               // The top of stack is popped first as operand a.
               a_in    = (count_ff != '0) ? top_ff : POP_EMPTY_VALUE;
               if (req_payload.operation == OP_PUSH) begin
                  if (count_ff < DEPTH_C) begin
                     count_in = count_ff + CW'(1);
                     top_in   = req_payload.operand_value;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  state_in = S_DONE;
               end else if (req_payload.operation <= OP_POW) begin
                  state_in = S_READB;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READB: begin
            if (!has_two) begin
               unf_in = 1'b1;
            end
            case (op_ff)
               OP_ADD: begin
                  res_in   = b_val + a_ff;
                  state_in = S_WRITE;
               end
               OP_SUB: begin
                  res_in   = b_val - a_ff;
                  state_in = S_WRITE;
               end
               OP_MUL: begin
                  res_in   = DATA_W'(b_val * a_ff);
                  state_in = S_WRITE;
               end
               default: begin
                  state_in = S_ALU;
               end
            endcase
         end
         S_ALU: begin
            if (alu_sts.done) begin
               res_in   = alu_result;
               dz_in    = dz_ff || alu_sts.div_zero;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // Two pops and one push: the count drops by one, or becomes one
            // when the stack held fewer than two entries.
            count_in = has_two ? count_ff - CW'(1) : CW'(1);
            top_in   = res_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_data_in.result_value    = (count_ff != '0) ? top_ff : '0;
               rsp_data_in.divide_by_zero  = dz_ff;
               rsp_data_in.stack_overflow  = ovf_ff;
               rsp_data_in.stack_underflow = unf_ff;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               dz_in        = 1'b0;
               ovf_in       = 1'b0;
               unf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dz_ff        <= 1'b0;
         ovf_ff       <= 1'b0;
         unf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dz_ff        <= dz_in;
         ovf_ff       <= ovf_in;
         unf_ff       <= unf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      last_ff     <= last_in;
      top_ff      <= top_in;
      a_ff        <= a_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   pse_stack_mem #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (cnt_m2[AW-1:0]),
      .rd_data (rd_data)
   );

   pse_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .b      (b_val),
      .a      (a_ff),
      .sts    (alu_sts),
      .result (alu_result)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // The stack count never passes the stack depth.
   `PSE_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= DEPTH_C)
   // An operator always leaves at least one entry on the stack.
   `PSE_ASSERT_NEXT(a_op_leaves_top, clock, reset, state_ff == S_WRITE, count_ff != '0)
   // Emitting a response empties the stack and clears the flags.
   `PSE_ASSERT_NEXT(a_emit_clears, clock, reset, emit,
      count_ff == '0 && !dz_ff && !ovf_ff && !unf_ff && rsp_valid_ff)
   // The iterative unit only reports completion while the evaluator waits for it.
   `PSE_ASSERT_HOLDS(a_alu_done_waited, clock, reset, !alu_sts.done || state_ff == S_ALU)

endmodule
